>>> design/lbca_pkg.sv
// shared types and constants for the linked block chain allocator
// no dependencies
`default_nettype none

package lbca_pkg;

   localparam int unsigned DEFAULT_NUM_BLOCKS = 256;
   localparam logic [8:0]  DISK_BLOCKS_RESET  = 9'd256;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_NOTHEAD = 2'd2,
      ST_ZERO    = 2'd3
   } status_type;

   typedef enum logic {
      OP_CREATE = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef struct packed {
      logic       op;
      logic [8:0] block_count;
      logic [7:0] head_block;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] first_block;
      logic [7:0] last_block;
      logic [8:0] blocks_moved;
      logic [8:0] free_left;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/lbca_table.sv
// block table memory: one entry per block holding link, end, free and head bits
// one write port, one read port with registered read data; uses no package
`default_nettype none

module lbca_table #(
   parameter int unsigned NUM_BLOCKS = 256,
   parameter int unsigned IW         = 8
) (
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [IW-1:0]   wr_addr,
   input  wire logic [IW+2:0]   wr_data,
   input  wire logic [IW-1:0]   rd_addr,
   output logic      [IW+2:0]   rd_data
);

   logic [IW+2:0] mem_ff [NUM_BLOCKS];
   logic [IW+2:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/linked_block_chain_allocator.sv
// Linked block chain allocator over a table of next-block links held in one
// synchronous memory (lbca_table); depends on lbca_pkg.
// After reset and after every csr write a clearing pass marks every block
// free, with busy high. A create scans blocks from index 0, one block a cycle,
// until it has the requested count or reaches the disk size. A delete walks
// the chain one block a cycle through the memory read port. Zero-count,
// no-space and out-of-range delete requests are answered from the idle state
// without a scan or walk; a delete of an in-range block that is not a chain
// head is answered once that block has been read. Each result shows on
// rsp_data for exactly one cycle with rsp_valid; the receiver cannot stall it.
`default_nettype none

module linked_block_chain_allocator #(
   parameter int unsigned NUM_BLOCKS = lbca_pkg::DEFAULT_NUM_BLOCKS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire lbca_pkg::req_type req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output lbca_pkg::rsp_type     rsp_data,
   input  wire logic             csr_we,
   input  wire logic [8:0]       csr_wdata
);

   localparam int unsigned IW = $clog2(NUM_BLOCKS);
   localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
   localparam int unsigned WW = (CW > 9) ? CW : 9;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FINISH,
      S_WALK
   } state_type;

   state_type         state_ff, state_in;
   logic [8:0]        disk_ff, disk_in;
   logic [CW-1:0]     free_ff, free_in;
   logic [CW-1:0]     clr_ff, clr_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic [IW-1:0]     eval_ff, eval_in;
   logic              rvalid_ff, rvalid_in;
   logic [CW-1:0]     got_ff, got_in;
   logic [8:0]        want_ff, want_in;
   logic [IW-1:0]     first_ff, first_in;
   logic [IW-1:0]     prev_ff, prev_in;
   logic [IW-1:0]     cur_ff, cur_in;
   logic              head_step_ff, head_step_in;
   logic [7:0]        head_ff, head_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lbca_pkg::rsp_type rsp_ff, rsp_in;

   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [IW+2:0]     wr_data;
   logic [IW-1:0]     rd_addr;
   logic [IW+2:0]     rd_data;

   logic [IW-1:0]     rd_link;
   logic              rd_end, rd_free, rd_head;
   logic [CW-1:0]     d_blocks;
   logic [WW-1:0]     disk_wide;
   logic              hit;
   logic [CW-1:0]     got_n, freed_n;
   logic [WW-1:0]     sum_wide;
   logic              stop;

   assign {rd_link, rd_end, rd_free, rd_head} = rd_data;

   lbca_table #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .IW         (IW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      disk_wide = WW'(disk_ff);
      d_blocks  = (disk_wide > WW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(disk_wide);
   end

   always_comb begin
      state_in     = state_ff;
      disk_in      = disk_ff;
      free_in      = free_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      eval_in      = eval_ff;
      rvalid_in    = 1'b0;
      got_in       = got_ff;
      want_in      = want_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      head_step_in = head_step_ff;
      head_in      = head_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_ff[IW-1:0];
      wr_data      = {IW'(0), 1'b0, 1'b1, 1'b0};
      rd_addr      = scan_ff[IW-1:0];
      hit          = 1'b0;
      got_n        = got_ff;
      freed_n      = got_ff;
      sum_wide     = '0;
      stop         = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(NUM_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               head_in = req_data.head_block;
               if (req_data.op == lbca_pkg::OP_CREATE) begin
                  if (req_data.block_count == 9'd0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{status: lbca_pkg::ST_ZERO, first_block: 8'd0,
                                last_block: 8'd0, blocks_moved: 9'd0,
                                free_left: 9'(free_ff)};
                  end else if (WW'(req_data.block_count) > WW'(free_ff)) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{status: lbca_pkg::ST_NOSPACE, first_block: 8'd0,
                                last_block: 8'd0, blocks_moved: 9'd0,
                                free_left: 9'(free_ff)};
                  end else begin
                     want_in  = req_data.block_count;
                     scan_in  = '0;
                     got_in   = '0;
                     state_in = S_SCAN;
                  end
               end else begin
                  if (WW'(req_data.head_block) >= WW'(d_blocks)) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{status: lbca_pkg::ST_NOTHEAD,
                                first_block: req_data.head_block,
                                last_block: 8'd0, blocks_moved: 9'd0,
                                free_left: 9'(free_ff)};
                  end else begin
                     rd_addr      = IW'(req_data.head_block);
                     cur_in       = IW'(req_data.head_block);
                     head_step_in = 1'b1;
                     got_in       = '0;
                     state_in     = S_WALK;
                  end
               end
            end
         end
         S_SCAN: begin
            // read of scan_ff goes out while the block read last cycle is judged
            hit   = rvalid_ff && rd_free;
            got_n = got_ff + CW'(hit);
            if (hit) begin
               prev_in = eval_ff;
               if (got_ff == '0) begin
                  first_in = eval_ff;
               end else begin
                  // link the pending block to this one now that it is known
                  wr_en   = 1'b1;
                  wr_addr = prev_ff;
                  wr_data = {eval_ff, 1'b0, 1'b0, (got_ff == CW'(1))};
               end
            end
            got_in = got_n;
            if (WW'(got_n) == WW'(want_ff) || scan_ff >= d_blocks) begin
               state_in = S_FINISH;
            end else begin
               rvalid_in = 1'b1;
               eval_in   = scan_ff[IW-1:0];
               scan_in   = scan_ff + CW'(1);
            end
         end
         S_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (got_ff == '0) begin
               rsp_in = '{status: lbca_pkg::ST_NOSPACE, first_block: 8'd0,
                          last_block: 8'd0, blocks_moved: 9'd0,
                          free_left: 9'(free_ff)};
            end else begin
               wr_en   = 1'b1;
               wr_addr = prev_ff;
               wr_data = {IW'(0), 1'b1, 1'b0, (got_ff == CW'(1))};
               free_in = (free_ff >= got_ff) ? free_ff - got_ff : '0;
               rsp_in  = '{status: lbca_pkg::ST_OK, first_block: 8'(first_ff),
                           last_block: 8'(prev_ff), blocks_moved: 9'(got_ff),
                           free_left: 9'((free_ff >= got_ff) ? free_ff - got_ff
                                                               : '0)};
            end
         end
         S_WALK: begin
            head_step_in = 1'b0;
            freed_n      = got_ff + CW'(1);
            if (head_step_ff && !rd_head) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               rsp_in = '{status: lbca_pkg::ST_NOTHEAD, first_block: head_ff,
                          last_block: 8'd0, blocks_moved: 9'd0,
                          free_left: 9'(free_ff)};
            end else begin
               if (!head_step_ff && rd_free) begin
                  // walk ran into a free block: it is not part of the chain
                  stop    = 1'b1;
                  freed_n = got_ff;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = cur_ff;
                  wr_data = {rd_link, 1'b0, 1'b1, 1'b0};
                  got_in  = freed_n;
                  stop    = rd_end || (CW'(rd_link) >= d_blocks) || (rd_link == cur_ff)
                            || (freed_n == CW'(NUM_BLOCKS));
                  rd_addr = rd_link;
                  cur_in  = rd_link;
               end
               if (stop) begin
                  sum_wide = WW'(free_ff) + WW'(freed_n);
                  free_in  = (sum_wide > WW'(d_blocks)) ? d_blocks : CW'(sum_wide);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  rsp_in = '{status: lbca_pkg::ST_OK, first_block: head_ff,
                             last_block: 8'd0, blocks_moved: 9'(freed_n),
                             free_left: 9'((sum_wide > WW'(d_blocks)) ? d_blocks
                                                                       : CW'(sum_wide))};
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase

      // a csr transfer formats the disk and restarts the clearing pass
      if (csr_we) begin
         disk_in  = csr_wdata;
         free_in  = (WW'(csr_wdata) > WW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                       : CW'(csr_wdata);
         clr_in   = '0;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         disk_ff      <= lbca_pkg::DISK_BLOCKS_RESET;
         free_ff      <= (WW'(lbca_pkg::DISK_BLOCKS_RESET) > WW'(NUM_BLOCKS))
                         ? CW'(NUM_BLOCKS) : CW'(lbca_pkg::DISK_BLOCKS_RESET);
         clr_ff       <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_step_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         disk_ff      <= disk_in;
         free_ff      <= free_in;
         clr_ff       <= clr_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         head_step_ff <= head_step_in;
      end
      scan_ff  <= scan_in;
      eval_ff  <= eval_in;
      got_ff   <= got_in;
      want_ff  <= want_in;
      first_ff <= first_in;
      prev_ff  <= prev_in;
      cur_ff   <= cur_in;
      head_ff  <= head_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
